// File: hw/rtl/lbrc_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring capture package
// Shared constants, action codes, controller states, the controller command
// word and the snapshot length helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lbrc_pkg;

  // Ring geometry.
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);

  // Fixed field widths of the channels.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned LINE_W   = 32;

  // Ring depth at the widths where it is compared.
  localparam logic [ADDR_W:0]  DEPTH_EXT = (ADDR_W + 1)'(RING_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(RING_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(RING_DEPTH - 1);

  // Byte that counts as the end of a line.
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Action codes carried by an input word.
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_en;      // Accept the input word: update state, start read.
    logic result_load;  // Load the output register from the finished word.
  } cmd_t;

  // Bytes a snapshot yields: min(fill, capacity - 1), zero for no capacity.
  function automatic logic [LEN_W-1:0] snap_len(input logic [LEN_W-1:0] fill,
                                                input logic [LEN_W-1:0] cap);
    logic [LEN_W-1:0] lim;
    lim = cap - LEN_W'(1);
    if (cap == '0) begin
      return '0;
    end
    return (fill < lim) ? fill : lim;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lbrc_in_if.sv
// ----------------------------------------------------------------------------
// Byte ring capture input channel
// Valid/ready channel carrying one action word into the ring.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [lbrc_pkg::ACTION_W-1:0] action;
  logic [lbrc_pkg::BYTE_W-1:0]   data_byte;
  logic [lbrc_pkg::LEN_W-1:0]    read_offset;
  logic [lbrc_pkg::LEN_W-1:0]    buffer_length;

  modport source (output valid, action, data_byte, read_offset, buffer_length,
                  input ready);
  modport sink   (input valid, action, data_byte, read_offset, buffer_length,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lbrc_out_if.sv
// ----------------------------------------------------------------------------
// Byte ring capture result channel
// Valid/ready channel carrying one result word out of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbrc_pkg::BYTE_W-1:0] read_byte;
  logic [lbrc_pkg::LEN_W-1:0]  snapshot_length;
  logic [lbrc_pkg::LEN_W-1:0]  stored_bytes;
  logic [lbrc_pkg::LINE_W-1:0] line_total;

  modport source (output valid, read_byte, snapshot_length, stored_bytes,
                  line_total, input ready);
  modport sink   (input valid, read_byte, snapshot_length, stored_bytes,
                  line_total, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lbrc_ctrl.sv
// ----------------------------------------------------------------------------
// Byte ring capture controller
// Two-state sequencer: takes one word, then loads its result into the output
// register as soon as that register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lbrc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lbrc_pkg::cmd_t      cmd_o
);

  lbrc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             load;

  // Output decode.
  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      lbrc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      lbrc_pkg::ST_RESULT: begin
        load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept            = in_valid_i && in_ready_o;
  assign cmd_o.item_en     = accept;
  assign cmd_o.result_load = load;
  assign out_valid_o       = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbrc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lbrc_pkg::ST_RESULT;
        end
      end
      lbrc_pkg::ST_RESULT: begin
        if (load) begin
          state_d = lbrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbrc_pkg::ST_IDLE;
      end
    endcase
  end

  // The output word stays valid until it is taken or replaced.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbrc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted word always moves the controller to the result state in the
  // next cycle.
  a_accept_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == lbrc_pkg::ST_RESULT))
    else $error("accepted word did not move the controller to result");

  // Loading a result never leaves the output register empty.
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("result load did not raise output valid");

  // A stalled result word stays valid until the receiver takes it.
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("output word dropped while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/lbrc_datapath.sv
// ----------------------------------------------------------------------------
// Byte ring capture datapath
// Byte memory, head pointer, fill and line counters, the read address path
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbrc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lbrc_pkg::cmd_t                cmd_i,
  input  wire logic [lbrc_pkg::ACTION_W-1:0] action_i,
  input  wire logic [lbrc_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic [lbrc_pkg::LEN_W-1:0]    read_offset_i,
  input  wire logic [lbrc_pkg::LEN_W-1:0]    buffer_length_i,
  output logic [lbrc_pkg::BYTE_W-1:0]        read_byte_o,
  output logic [lbrc_pkg::LEN_W-1:0]         snapshot_length_o,
  output logic [lbrc_pkg::LEN_W-1:0]         stored_bytes_o,
  output logic [lbrc_pkg::LINE_W-1:0]        line_total_o
);

  localparam int unsigned AW = lbrc_pkg::ADDR_W;
  localparam int unsigned LW = lbrc_pkg::LEN_W;

  logic [lbrc_pkg::BYTE_W-1:0] mem_q [lbrc_pkg::RING_DEPTH];

  logic [AW-1:0]               head_q, head_d;
  logic [LW-1:0]               fill_q, fill_d;
  logic [lbrc_pkg::LINE_W-1:0] lines_q, lines_d;
  logic [LW-1:0]               cap_q;
  logic                        hit_q;
  logic [lbrc_pkg::BYTE_W-1:0] rdata_q;

  logic [lbrc_pkg::BYTE_W-1:0] res_byte_q;
  logic [LW-1:0]               res_snap_q;
  logic [LW-1:0]               res_fill_q;
  logic [lbrc_pkg::LINE_W-1:0] res_lines_q;

  logic          is_write, is_read, is_clear;
  logic          full;
  logic [AW-1:0] start;
  logic [AW:0]   addr_sum;
  logic [AW-1:0] raddr;
  logic          hit;

  assign is_write = (action_i == lbrc_pkg::ACT_WRITE);
  assign is_read  = (action_i == lbrc_pkg::ACT_READ);
  assign is_clear = (action_i == lbrc_pkg::ACT_CLEAR);
  assign full     = (fill_q >= lbrc_pkg::DEPTH_LEN);

  // Oldest byte sits at index zero until the ring wraps, then at the head.
  assign start    = full ? head_q : '0;
  assign addr_sum = {1'b0, start} + {1'b0, read_offset_i[AW-1:0]};
  assign raddr    = (addr_sum >= lbrc_pkg::DEPTH_EXT) ?
                    AW'(addr_sum - lbrc_pkg::DEPTH_EXT) : addr_sum[AW-1:0];

  // A read hits when the offset lies inside the snapshot; reads leave the
  // state unchanged, so the current fill count applies.
  assign hit = is_read && (read_offset_i < lbrc_pkg::snap_len(fill_q, buffer_length_i));

  // Ring state update.
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    lines_d = lines_q;
    if (cmd_i.item_en) begin
      if (is_write) begin
        head_d = (head_q == lbrc_pkg::LAST_IDX) ? '0 : head_q + AW'(1);
        if (!full) begin
          fill_d = fill_q + LW'(1);
        end
        if (data_byte_i == lbrc_pkg::NEWLINE_BYTE && lines_q != '1) begin
          lines_d = lines_q + lbrc_pkg::LINE_W'(1);
        end
      end else if (is_clear) begin
        head_d  = '0;
        fill_d  = '0;
        lines_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      lines_q <= '0;
    end else begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      lines_q <= lines_d;
    end
  end

  // Byte memory: one write or one registered read per word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_en && is_write) begin
      mem_q[head_q] <= data_byte_i;
    end
    if (cmd_i.item_en && is_read) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Per-word side information kept for the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_en) begin
      cap_q <= buffer_length_i;
      hit_q <= hit;
    end
  end

  // Output register, loaded from the state after the word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      res_byte_q  <= hit_q ? rdata_q : '0;
      res_snap_q  <= lbrc_pkg::snap_len(fill_q, cap_q);
      res_fill_q  <= fill_q;
      res_lines_q <= lines_q;
    end
  end

  assign read_byte_o       = res_byte_q;
  assign snapshot_length_o = res_snap_q;
  assign stored_bytes_o    = res_fill_q;
  assign line_total_o      = res_lines_q;

  // Until the ring wraps the head equals the fill count.
  a_head_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q < lbrc_pkg::DEPTH_LEN) |-> (head_q == fill_q[AW-1:0]))
    else $error("head pointer out of step with fill count");

  // The fill count never passes the ring depth.
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= lbrc_pkg::DEPTH_LEN)
    else $error("fill count above ring depth");

  // A clear empties the ring and the line counter.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.item_en && is_clear) |=> (fill_q == '0 && head_q == '0 && lines_q == '0))
    else $error("clear did not empty the ring");

endmodule

`default_nettype wire

// File: hw/rtl/log_byte_ring_capture_core.sv
// ----------------------------------------------------------------------------
// Byte trace ring capture
// Ring of RING_DEPTH bytes that overwrites its oldest byte once full.
//
// Usage:
//   in_i carries one word per handshake: action (write, read, clear, no
//   operation), data_byte, read_offset and buffer_length. out_o returns
//   exactly one result word per input word, in order: the byte read (zero
//   unless a read falls inside the snapshot), the snapshot length, the fill
//   count and the newline count, all taken after the word's update.
//   At the input handshake the byte memory is read into a registered read
//   and the controller moves to its result state; there, once the output
//   register is free, that register loads from the registered read and the
//   controller returns to idle. A new word is taken only in idle, so the
//   next word waits until the last one has loaded its result.
//   Reset clears the head, fill count, newline count, the controller state
//   and the output valid flag; the byte memory itself is not cleared, and
//   only bytes written since the last clear or reset are ever read back.
//   The ring is usable right after reset, with no clearing pass.
//   When the receiver stalls, the result stays in the output register and
//   the next word is still taken; its result waits until that register is
//   taken, and no further word is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module log_byte_ring_capture_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lbrc_in_if.sink    in_i,
  lbrc_out_if.source out_o
);

  lbrc_pkg::cmd_t cmd;

  // Sequencer.
  lbrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Ring storage and counters.
  lbrc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .action_i          (in_i.action),
    .data_byte_i       (in_i.data_byte),
    .read_offset_i     (in_i.read_offset),
    .buffer_length_i   (in_i.buffer_length),
    .read_byte_o       (out_o.read_byte),
    .snapshot_length_o (out_o.snapshot_length),
    .stored_bytes_o    (out_o.stored_bytes),
    .line_total_o      (out_o.line_total)
  );

endmodule

`default_nettype wire
